### rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg - shared types and constants of the text console cursor
// widths, character codes, command kinds, register indexes and queue types
// ----------------------------------------------------------------------------
package tcc_pkg;

  // cursor coordinate width, cursor values wrap modulo 2**COORD_W
  localparam int COORD_W = 8;

  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 32;
  localparam int GEOM_W    = 8;
  localparam int CELL_W    = 7;
  localparam int PIX_W     = 14;
  localparam int TAB_STOP  = 8;
  localparam int TAB_BITS  = 3;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // width for comparing a coordinate against a geometry register
  localparam int CMP_W  = (COORD_W > GEOM_W) ? COORD_W : GEOM_W;
  // width of a coordinate times cell size product, at least the pixel width
  localparam int PROD_W = ((COORD_W + CELL_W) > PIX_W) ? (COORD_W + CELL_W) : PIX_W;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    KIND_GLYPH,
    KIND_NEWLINE,
    KIND_BACKSPACE,
    KIND_TAB
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS,
    REG_ROWS,
    REG_CELL_WIDTH,
    REG_CELL_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [GEOM_W-1:0] columns;
    logic [GEOM_W-1:0] rows;
    logic [CELL_W-1:0] cell_width;
    logic [CELL_W-1:0] cell_height;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } cmd_t;

  // one queue slot as seen at either side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qslot_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cursor_t;

endpackage

### rtl/core/tcc_in_if.sv
// ----------------------------------------------------------------------------
// tcc_in_if - character request channel
// valid/ready channel carrying one character and its colors
// ----------------------------------------------------------------------------
interface tcc_in_if;
  import tcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  modport source (output valid, char_code, fg_color, bg_color, input ready);
  modport sink   (input valid, char_code, fg_color, bg_color, output ready);
endinterface

### rtl/core/tcc_out_if.sv
// ----------------------------------------------------------------------------
// tcc_out_if - cell draw request channel
// valid/ready channel carrying one cell draw
// ----------------------------------------------------------------------------
interface tcc_out_if;
  import tcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [CHAR_W-1:0]  glyph;
  logic [COLOR_W-1:0] draw_fg;
  logic [COLOR_W-1:0] draw_bg;
  logic               last;

  modport source (output valid, pixel_x, pixel_y, glyph, draw_fg, draw_bg, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, glyph, draw_fg, draw_bg, last,
                  output ready);
endinterface

### rtl/core/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front - request intake and classification
// registers each incoming character and tags it as glyph, newline,
// backspace or tab before it enters the command queue
// ----------------------------------------------------------------------------
module tcc_front (
  input  logic            clk,
  input  logic            rst_n,
  tcc_in_if.sink          in_ch,
  output tcc_pkg::qslot_t push,
  input  logic            push_ready
);
  import tcc_pkg::*;

  logic  hold_valid_r, hold_valid_nxt;
  cmd_t  hold_cmd_r, hold_cmd_nxt;
  kind_t kind;

  always_comb begin
    case (in_ch.char_code)
      CH_NEWLINE:   kind = KIND_NEWLINE;
      CH_BACKSPACE: kind = KIND_BACKSPACE;
      CH_TAB:       kind = KIND_TAB;
      default:      kind = KIND_GLYPH;
    endcase
  end

  assign in_ch.ready = !hold_valid_r || push_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (in_ch.ready) begin
      hold_valid_nxt = in_ch.valid;
      if (in_ch.valid) begin
        hold_cmd_nxt.kind      = kind;
        hold_cmd_nxt.char_code = in_ch.char_code;
        hold_cmd_nxt.fg        = in_ch.fg_color;
        hold_cmd_nxt.bg        = in_ch.bg_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_cmd_r <= hold_cmd_nxt;
  end

  assign push.valid = hold_valid_r;
  assign push.cmd   = hold_cmd_r;

endmodule

### rtl/core/tcc_queue.sv
// ----------------------------------------------------------------------------
// tcc_queue - command queue between intake and cursor engine
// small register fifo, head visible without a read cycle
// ----------------------------------------------------------------------------
module tcc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  tcc_pkg::qslot_t push,
  output logic            push_ready,
  output tcc_pkg::qslot_t head,
  input  logic            pop
);
  import tcc_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QDEPTH - 1)) n = '0;
    else                          n = p + 1'b1;
    return n;
  endfunction

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("cursor engine popped an empty queue");
`endif

endmodule

### rtl/core/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back - cursor engine and draw pipeline
// keeps the cursor, walks each command one cell per cycle unless stalled,
// then scales the cell coordinates to pixels in a registered output stage
// ----------------------------------------------------------------------------
module tcc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tcc_pkg::cfg_t   cfg,
  input  tcc_pkg::qslot_t head,
  output logic            pop,
  tcc_out_if.source       out_ch
);
  import tcc_pkg::*;

  // cursor and tab progress
  cursor_t           cur_r, cur_nxt;
  logic              tab_active_r, tab_active_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;

  // cell stage
  logic               a_valid_r, a_valid_nxt;
  cursor_t            a_pos_r, a_pos_nxt;
  logic [CHAR_W-1:0]  a_glyph_r, a_glyph_nxt;
  logic [COLOR_W-1:0] a_fg_r, a_fg_nxt;
  logic [COLOR_W-1:0] a_bg_r, a_bg_nxt;
  logic               a_last_r, a_last_nxt;

  // pixel stage
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_x_r, out_y_r;
  logic [CHAR_W-1:0]  out_glyph_r;
  logic [COLOR_W-1:0] out_fg_r, out_bg_r;
  logic               out_last_r;

  logic              a_ready, b_ready;
  logic [GEOM_W-1:0] eff_cols, eff_rows;
  cursor_t           bs_pos, step_pos, nl_pos;
  logic [CNT_W-1:0]  tab_cnt;
  logic [PROD_W-1:0] prod_x, prod_y;

  function automatic cursor_t wrap_cursor(cursor_t c, logic [GEOM_W-1:0] ncol,
                                          logic [GEOM_W-1:0] nrow);
    cursor_t w;
    w = c;
    if (CMP_W'(w.col) >= CMP_W'(ncol)) begin
      w.row = w.row + 1'b1;
      w.col = '0;
    end
    if (CMP_W'(w.row) >= CMP_W'(nrow)) begin
      w.row = '0;
    end
    return w;
  endfunction

  function automatic logic [COORD_W-1:0] geom_last(logic [GEOM_W-1:0] n);
    logic [CMP_W-1:0] v;
    v = CMP_W'(n - 1'b1);
    return v[COORD_W-1:0];
  endfunction

  assign eff_cols = (cfg.columns == '0) ? GEOM_W'(1) : cfg.columns;
  assign eff_rows = (cfg.rows == '0)    ? GEOM_W'(1) : cfg.rows;

  assign b_ready = !out_valid_r || out_ch.ready;
  assign a_ready = !a_valid_r || b_ready;

  // backspace target cell, before the overflow checks
  always_comb begin
    bs_pos = cur_r;
    if (cur_r.col == '0) begin
      bs_pos.col = geom_last(eff_cols);
      if (cur_r.row == '0) bs_pos.row = geom_last(eff_rows);
      else                 bs_pos.row = cur_r.row - 1'b1;
    end else begin
      bs_pos.col = cur_r.col - 1'b1;
    end
  end

  // one cell forward, and newline
  always_comb begin
    step_pos     = cur_r;
    step_pos.col = cur_r.col + 1'b1;
    nl_pos       = cur_r;
    nl_pos.col   = '0;
    nl_pos.row   = cur_r.row + 1'b1;
  end

  // spaces left in a tab, fixed on its first cell
  assign tab_cnt = tab_active_r ? rem_r
                 : CNT_W'(TAB_STOP) - CNT_W'(cur_r.col[TAB_BITS-1:0]);

  always_comb begin
    pop            = 1'b0;
    cur_nxt        = cur_r;
    tab_active_nxt = tab_active_r;
    rem_nxt        = rem_r;
    a_valid_nxt    = a_valid_r;
    a_pos_nxt      = a_pos_r;
    a_glyph_nxt    = a_glyph_r;
    a_fg_nxt       = a_fg_r;
    a_bg_nxt       = a_bg_r;
    a_last_nxt     = a_last_r;
    if (a_ready) begin
      a_valid_nxt = 1'b0;
      if (head.valid) begin
        a_fg_nxt = head.cmd.fg;
        a_bg_nxt = head.cmd.bg;
        case (head.cmd.kind)
          KIND_NEWLINE: begin
            cur_nxt = wrap_cursor(nl_pos, eff_cols, eff_rows);
            pop     = 1'b1;
          end
          KIND_BACKSPACE: begin
            a_valid_nxt = 1'b1;
            a_pos_nxt   = bs_pos;
            a_glyph_nxt = CH_SPACE;
            a_last_nxt  = 1'b1;
            cur_nxt     = wrap_cursor(bs_pos, eff_cols, eff_rows);
            pop         = 1'b1;
          end
          KIND_TAB: begin
            a_valid_nxt = 1'b1;
            a_pos_nxt   = cur_r;
            a_glyph_nxt = CH_SPACE;
            a_last_nxt  = (tab_cnt == CNT_W'(1));
            cur_nxt     = wrap_cursor(step_pos, eff_cols, eff_rows);
            if (tab_cnt == CNT_W'(1)) begin
              pop            = 1'b1;
              tab_active_nxt = 1'b0;
            end else begin
              tab_active_nxt = 1'b1;
              rem_nxt        = tab_cnt - 1'b1;
            end
          end
          default: begin
            a_valid_nxt = 1'b1;
            a_pos_nxt   = cur_r;
            a_glyph_nxt = head.cmd.char_code;
            a_last_nxt  = 1'b1;
            cur_nxt     = wrap_cursor(step_pos, eff_cols, eff_rows);
            pop         = 1'b1;
          end
        endcase
      end
    end
  end

  assign prod_x = PROD_W'(a_pos_r.col) * PROD_W'(cfg.cell_width);
  assign prod_y = PROD_W'(a_pos_r.row) * PROD_W'(cfg.cell_height);

  assign out_valid_nxt = b_ready ? a_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      tab_active_r <= 1'b0;
      a_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_r        <= cur_nxt;
      tab_active_r <= tab_active_nxt;
      a_valid_r    <= a_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    a_pos_r   <= a_pos_nxt;
    a_glyph_r <= a_glyph_nxt;
    a_fg_r    <= a_fg_nxt;
    a_bg_r    <= a_bg_nxt;
    a_last_r  <= a_last_nxt;
    if (b_ready) begin
      out_x_r     <= prod_x[PIX_W-1:0];
      out_y_r     <= prod_y[PIX_W-1:0];
      out_glyph_r <= a_glyph_r;
      out_fg_r    <= a_fg_r;
      out_bg_r    <= a_bg_r;
      out_last_r  <= a_last_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pixel_x = out_x_r;
  assign out_ch.pixel_y = out_y_r;
  assign out_ch.glyph   = out_glyph_r;
  assign out_ch.draw_fg = out_fg_r;
  assign out_ch.draw_bg = out_bg_r;
  assign out_ch.last    = out_last_r;

`ifndef SYNTHESIS
  a_tab_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    tab_active_r |-> (rem_r != '0) && (rem_r < CNT_W'(TAB_STOP)))
    else $error("tab remainder out of range");

  a_tab_head: assert property (@(posedge clk) disable iff (!rst_n)
    tab_active_r |-> head.valid && (head.cmd.kind == KIND_TAB))
    else $error("tab in progress without a tab at the queue head");
`endif

endmodule

### rtl/core/text_console_cursor.sv
// ----------------------------------------------------------------------------
// text_console_cursor - text console cursor control
// turns a stream of characters into cell draw requests on a character grid
// ----------------------------------------------------------------------------
// Each character request on in_ch moves a cursor on a grid of columns by rows
// cells and produces zero or more draw requests on out_ch, each with the cell's
// top left pixel, the glyph and the request's colors, last set on the final
// draw of a character. A glyph draws once and advances; a backspace steps back
// (wrapping to the last column of the previous row, and from row 0 to the last
// row) and draws a space; a tab draws one to eight spaces up to the next
// multiple of eight; a newline draws nothing. The cursor engine handles one
// cell per clock while out_ch is not stalled; the intake stage and a two entry
// command queue keep accepting while a tab is being expanded or out_ch is
// stalled. A request passes the intake register, the queue, the cell stage
// and the pixel multiply stage before its first draw. The user must write the
// geometry registers through cfg_* only while the block is idle; the block
// itself does not enforce this. A columns or rows value of 0 acts as 1.
// ----------------------------------------------------------------------------
module text_console_cursor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::CFG_DAT_W-1:0] cfg_wdata,
  tcc_in_if.sink                        in_ch,
  tcc_out_if.source                     out_ch
);
  import tcc_pkg::*;

  // geometry registers
  cfg_t cfg_r, cfg_nxt;

  // front to queue, queue to back
  qslot_t push, head;
  logic   push_ready, pop;

  // register writes, decoded by index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLUMNS:     cfg_nxt.columns     = cfg_wdata[GEOM_W-1:0];
        REG_ROWS:        cfg_nxt.rows        = cfg_wdata[GEOM_W-1:0];
        REG_CELL_WIDTH:  cfg_nxt.cell_width  = cfg_wdata[CELL_W-1:0];
        REG_CELL_HEIGHT: cfg_nxt.cell_height = cfg_wdata[CELL_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // reset geometry: 80 x 25 cells of 8 x 16 pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns     <= GEOM_W'(80);
      cfg_r.rows        <= GEOM_W'(25);
      cfg_r.cell_width  <= CELL_W'(8);
      cfg_r.cell_height <= CELL_W'(16);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // intake: register and classify each request
  tcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  // decouples intake from tab expansion and output stalls
  tcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // cursor engine and pixel output stage
  tcc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
